/* rtl/kvt_pkg.sv */
// shared types and constants for the keyed value table
package kvt_pkg;

   localparam int CAPACITY    = 32;
   localparam int KEY_BITS    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W       = (KEY_BITS > VALUE_BITS) ? KEY_BITS : VALUE_BITS;
   localparam int OUT_CNT_W   = 6;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_ERASE  = 3'd1;
   localparam logic [2:0] OP_GET    = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_COUNT  = 3'd4;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_DUP   = 2'd2;
   localparam logic [1:0] ERR_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [31:0]          read_value;
      logic [OUT_CNT_W-1:0] match_count;
      logic [OUT_CNT_W-1:0] occupancy;
      logic [1:0]           error;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

endpackage

/* rtl/kvt_store.sv */
// entry memory: one write port, one read port with registered data
module kvt_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [kvt_pkg::ADDR_W-1:0] wr_addr,
   input  kvt_pkg::entry_type        wr_data,
   input  logic                      rd_en,
   input  logic [kvt_pkg::ADDR_W-1:0] rd_addr,
   output kvt_pkg::entry_type        rd_data
);
   import kvt_pkg::*;

   entry_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/keyed_value_table_unit.sv */
// keyed value table: packed key/value entries with linear search and shift-down erase
// one request at a time; the next can be taken in the same cycle its result word is offered
// erase: scan to the hit, then one cycle per moved entry
// a result word left waiting holds the block; reset empties the table, entries undefined
module keyed_value_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kvt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kvt_pkg::rsp_type rsp_data
);
   import kvt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_W-1:0]     pidx_ff, pidx_in;
   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] rdval_ff, rdval_in;
   logic [CNT_W-1:0]      match_ff, match_in;
   logic [1:0]            err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type         wr_data, rd_data;

   logic [CMP_W-1:0] cmp_a, cmp_b;
   logic             cmp_eq;
   logic             is_count;

   kvt_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the single comparator: key for lookups, value for count
   assign is_count = (op_ff == OP_COUNT);
   assign cmp_a    = is_count ? CMP_W'(rd_data.value) : CMP_W'(rd_data.key);
   assign cmp_b    = is_count ? CMP_W'(val_ff) : CMP_W'(key_ff);
   assign cmp_eq   = (cmp_a == cmp_b);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      rdval_in     = rdval_ff;
      match_in     = match_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = '{key: key_ff, value: val_ff};
      rd_en        = 1'b0;
      rd_addr      = idx_ff[ADDR_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               key_in   = KEY_BITS'(req_data.key);
               val_in   = VALUE_BITS'(req_data.value);
               found_in = 1'b0;
               rdval_in = '0;
               match_in = '0;
               err_in   = ERR_NONE;
               idx_in   = '0;
               case (req_data.op)
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        err_in   = ERR_FULL;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_ERASE: begin
                     if (count_ff == '0) begin
                        err_in   = ERR_EMPTY;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_GET, OP_COUNT: begin
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (pend_ff && cmp_eq && is_count) begin
               match_in = match_ff + CNT_W'(1);
            end
            if (pend_ff && cmp_eq && !is_count) begin
               // key hit: any later read is dropped
               case (op_ff)
                  OP_INSERT: begin
                     err_in   = ERR_DUP;
                     state_in = ST_FINISH;
                  end
                  OP_ERASE: begin
                     found_in = 1'b1;
                     if (CNT_W'(pidx_ff) + CNT_W'(1) >= count_ff) begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = ST_FINISH;
                     end else begin
                        idx_in   = CNT_W'(pidx_ff) + CNT_W'(1);
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_GET: begin
                     found_in = 1'b1;
                     rdval_in = rd_data.value;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end else if (idx_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[ADDR_W-1:0];
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
               pidx_in = idx_ff[ADDR_W-1:0];
            end else if (!pend_ff) begin
               // scan finished without a key hit
               if (op_ff == OP_INSERT) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_FINISH;
            end
         end

         ST_SHIFT: begin
            // read entry n while writing entry n-1 back one place lower
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff - ADDR_W'(1);
               wr_data = rd_data;
            end
            if (idx_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[ADDR_W-1:0];
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
               pidx_in = idx_ff[ADDR_W-1:0];
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = found_ff;
               rsp_in.read_value  = 32'(rdval_ff);
               rsp_in.match_count = OUT_CNT_W'(match_ff);
               rsp_in.occupancy   = OUT_CNT_W'(count_ff);
               rsp_in.error       = err_ff;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      val_ff   <= val_in;
      idx_ff   <= idx_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      rdval_ff <= rdval_in;
      match_ff <= match_in;
      err_ff   <= err_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* tb/sv/keyed_value_table_unit_tb.sv */
// testbench for the keyed value table: directed rows, then random bursts against a table model
module keyed_value_table_unit_tb;
   import kvt_pkg::*;

   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam int RANDOM_WORDS  = 900;
   localparam int MAX_GAP       = 13;
   localparam int PRESSURE_AT   = 300;
   localparam int PRESSURE_HOLD = 600;
   localparam int DRAIN_CYCLES  = 2 * CAPACITY + 16;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int REPORT_LIMIT  = 10;
   localparam int KEY_POOL      = 16;
   localparam int VALUE_POOL    = 6;

   typedef struct packed {
      req_type word;
      bit      typed;
      rsp_type answer;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // typed expectation travels alongside the word on offer
   bit      row_typed  = 1'b0;
   rsp_type row_answer = '0;

   logic [KEY_BITS-1:0]   model_key   [CAPACITY];
   logic [VALUE_BITS-1:0] model_value [CAPACITY];
   int                    model_fill = 0;

   rsp_type      pending_rsp_q [$];
   stim_row_type directed_rows [$];
   logic [15:0]  key_pool   [KEY_POOL];
   logic [31:0]  value_pool [VALUE_POOL];

   int requests_sent  = 0;
   int responses_seen = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int full_hits      = 0;
   int dup_hits       = 0;
   int empty_hits     = 0;
   bit stim_done      = 1'b0;
   bit send_steady    = 1'b0;

   keyed_value_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // applies one request to the local table and returns the response it should produce
   function automatic rsp_type table_apply(input req_type w);
      rsp_type r;
      int      pos;
      int      hit_total;
      r         = '0;
      pos       = -1;
      hit_total = 0;
      for (int i = 0; i < model_fill; i++) begin
         if (pos < 0 && model_key[i] == w.key[KEY_BITS-1:0]) pos = i;
      end
      case (w.op)
         OP_INSERT: begin
            if (model_fill >= CAPACITY) begin
               r.error = ERR_FULL;
            end else if (pos >= 0) begin
               r.error = ERR_DUP;
            end else begin
               model_key[model_fill]   = w.key[KEY_BITS-1:0];
               model_value[model_fill] = w.value[VALUE_BITS-1:0];
               model_fill++;
            end
         end
         OP_ERASE: begin
            if (model_fill == 0) begin
               r.error = ERR_EMPTY;
            end else if (pos >= 0) begin
               for (int i = pos; i + 1 < model_fill; i++) begin
                  model_key[i]   = model_key[i + 1];
                  model_value[i] = model_value[i + 1];
               end
               model_fill--;
               r.found = 1'b1;
            end
         end
         OP_GET: begin
            if (pos >= 0) begin
               r.found      = 1'b1;
               r.read_value = model_value[pos];
            end
         end
         OP_CLEAR: model_fill = 0;
         OP_COUNT: begin
            for (int i = 0; i < model_fill; i++) begin
               if (model_value[i] == w.value[VALUE_BITS-1:0]) hit_total++;
            end
            r.match_count = OUT_CNT_W'(hit_total);
         end
         default: ;
      endcase
      r.occupancy = OUT_CNT_W'(model_fill);
      return r;
   endfunction

   function automatic logic [15:0] pick_key();
      if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL - 1)];
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, VALUE_POOL - 1)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return OP_INSERT;
      if (roll < 55) return OP_ERASE;
      if (roll < 80) return OP_GET;
      if (roll < 92) return OP_COUNT;
      if (roll < 95) return OP_CLEAR;
      return 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
   endfunction

   task automatic add_row(input logic [2:0] op, input logic [15:0] key,
                          input logic [31:0] value, input bit typed,
                          input logic found, input logic [31:0] rd,
                          input logic [5:0] mc, input logic [5:0] occ,
                          input logic [1:0] err);
      stim_row_type row;
      row = {op, key, value, typed, found, rd, mc, occ, err};
      directed_rows.push_back(row);
   endtask

   task automatic offer_request(input logic [2:0] op, input logic [15:0] key,
                                input logic [31:0] value, input bit typed,
                                input rsp_type answer);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= {op, key, value};
      row_typed  <= typed;
      row_answer <= answer;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   initial begin : req_side
      stim_row_type row;
      int           kind;
      logic [15:0]  base;
      logic [31:0]  fill_value;
      bit           one_value;
      foreach (key_pool[i]) key_pool[i] = 16'($urandom);
      foreach (value_pool[i]) value_pool[i] = $urandom;
      key_pool[0]   = 16'h0000;
      key_pool[1]   = 16'hFFFF;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;

      //       op               key       value          typed fnd rd            mc occ err
      add_row(OP_GET,          16'h0000, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_ERASE,        16'h0000, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 0, ERR_EMPTY);
      add_row(OP_COUNT,        16'h0000, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_INSERT,       16'h0000, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 1, ERR_NONE);
      add_row(OP_INSERT,       16'hFFFF, 32'hFFFF_FFFF, 1, 0, 32'h0000_0000, 0, 2, ERR_NONE);
      add_row(OP_INSERT,       16'h0000, 32'h1234_5678, 1, 0, 32'h0000_0000, 0, 2, ERR_DUP);
      add_row(OP_GET,          16'hFFFF, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 0, 2, ERR_NONE);
      add_row(OP_GET,          16'h0000, 32'hFFFF_FFFF, 1, 1, 32'h0000_0000, 0, 2, ERR_NONE);
      add_row(OP_COUNT,        16'h0000, 32'hFFFF_FFFF, 1, 0, 32'h0000_0000, 1, 2, ERR_NONE);
      add_row(OP_INSERT,       16'h5A5A, 32'hFFFF_FFFF, 0, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_INSERT,       16'hA5A5, 32'h0000_0000, 0, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_COUNT,        16'hFFFF, 32'hFFFF_FFFF, 0, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_GET,          16'h1234, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 4, ERR_NONE);
      add_row(OP_ERASE,        16'h1234, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 4, ERR_NONE);
      add_row(OP_ERASE,        16'h0000, 32'h0000_0000, 1, 1, 32'h0000_0000, 0, 3, ERR_NONE);
      add_row(OP_GET,          16'hA5A5, 32'h0000_0000, 0, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_UNUSED_FIRST, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 32'h0000_0000, 0, 3, ERR_NONE);
      add_row(OP_UNUSED_LAST,  16'h0000, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 3, ERR_NONE);
      add_row(OP_ERASE,        16'hA5A5, 32'h0000_0000, 0, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_COUNT,        16'h0000, 32'h0000_0000, 0, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_CLEAR,        16'hFFFF, 32'hFFFF_FFFF, 1, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_ERASE,        16'hFFFF, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 0, ERR_EMPTY);
      add_row(OP_GET,          16'hFFFF, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 0, ERR_NONE);
      add_row(OP_INSERT,       16'hFFFF, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 1, ERR_NONE);

      while (reset) @(posedge clock);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer_request(row.word.op, row.word.key, row.word.value, row.typed, row.answer);
      end

      while (requests_sent < directed_rows.size() + RANDOM_WORDS) begin
         kind        = $urandom_range(0, 9);
         send_steady = ($urandom_range(0, 3) == 0);
         if (kind < 2) begin
            // fill to capacity, then one fresh key and one repeated key on the full table
            base       = 16'($urandom);
            one_value  = 1'($urandom_range(0, 1));
            fill_value = pick_value();
            offer_request(OP_CLEAR, 16'($urandom), $urandom, 1'b0, '0);
            for (int i = 0; i <= CAPACITY + 1; i++) begin
               offer_request(OP_INSERT, 16'(base + (i % (CAPACITY + 1))),
                             one_value ? fill_value : pick_value(), 1'b0, '0);
            end
            offer_request(OP_COUNT, base, fill_value, 1'b0, '0);
            for (int i = 0; i < 8; i++) begin
               offer_request((i % 2 == 0) ? OP_ERASE : OP_GET,
                             16'(base + $urandom_range(0, CAPACITY)), pick_value(), 1'b0, '0);
            end
         end else if (kind < 9) begin
            for (int i = 0; i < 20; i++) offer_request(pick_op(), pick_key(), pick_value(), 1'b0, '0);
         end else begin
            for (int i = 0; i < 10; i++) begin
               offer_request(3'($urandom), 16'($urandom), $urandom, 1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin : rsp_side
      int gap;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 48 == 0) steady = ($urandom_range(0, 2) == 0);
         gap = steady ? 0 : $urandom_range(0, MAX_GAP);
         // long hold-off so the block backs up and stalls its input
         if (taken == PRESSURE_AT) gap = PRESSURE_HOLD;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   always @(posedge clock) begin : check_side
      rsp_type predicted;
      rsp_type expected;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = table_apply(req_data);
            pending_rsp_q.push_back(row_typed ? row_answer : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (pending_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected word: found %0b value %h count %0d occ %0d err %0d",
                           rsp_data.found, rsp_data.read_value, rsp_data.match_count,
                           rsp_data.occupancy, rsp_data.error);
            end else begin
               expected = pending_rsp_q.pop_front();
               case (expected.error)
                  ERR_FULL:  full_hits++;
                  ERR_DUP:   dup_hits++;
                  ERR_EMPTY: empty_hits++;
                  default: ;
               endcase
               if (rsp_data.found !== expected.found ||
                   rsp_data.read_value !== expected.read_value ||
                   rsp_data.match_count !== expected.match_count ||
                   rsp_data.occupancy !== expected.occupancy ||
                   rsp_data.error !== expected.error) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"word %0d mismatch: expected found %0b value %h count %0d ",
                               "occ %0d err %0d, got found %0b value %h count %0d occ %0d err %0d"},
                              responses_seen, expected.found, expected.read_value,
                              expected.match_count, expected.occupancy, expected.error,
                              rsp_data.found, rsp_data.read_value, rsp_data.match_count,
                              rsp_data.occupancy, rsp_data.error);
               end
            end
         end
      end
   end

   initial begin : finish_side
      wait (stim_done);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests offered, %0d responses compared, %0d mismatches",
               requests_sent, responses_seen, mismatch_count);
      $display("error responses: %0d table full, %0d duplicate key, %0d erase on empty",
               full_hits, dup_hits, empty_hits);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/kvt_pkg.sv
rtl/kvt_store.sv
rtl/keyed_value_table_unit.sv
tb/sv/keyed_value_table_unit_tb.sv
